// ----- hdl/system_control_coprocessor_macros.svh -----
// Assertion macros shared by the system control coprocessor modules
`ifndef SYSTEM_CONTROL_COPROCESSOR_MACROS_SVH
`define SYSTEM_CONTROL_COPROCESSOR_MACROS_SVH

// Property that holds at every clock edge out of reset
`define SCC_ASSERT_ALW(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scc_pkg.sv -----
// Types, constants and register codes of the system control coprocessor
`timescale 1ns / 1ps
package scc_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;

  // Default depth of the queue between decode and execute
  localparam int SCC_QUEUE_DEPTH = 2;

  // Access kind
  localparam logic CMD_MRC = 1'b0;
  localparam logic CMD_MCR = 1'b1;

  // Primary register numbers
  localparam logic [3:0] CRN_ID    = 4'd0;
  localparam logic [3:0] CRN_CTRL  = 4'd1;
  localparam logic [3:0] CRN_TTB   = 4'd2;
  localparam logic [3:0] CRN_DAC   = 4'd3;
  localparam logic [3:0] CRN_FSR   = 4'd5;
  localparam logic [3:0] CRN_FAR   = 4'd6;
  localparam logic [3:0] CRN_CACHE = 4'd7;
  localparam logic [3:0] CRN_TLB   = 4'd8;
  localparam logic [3:0] CRN_RBL   = 4'd9;
  localparam logic [3:0] CRN_PID   = 4'd13;
  localparam logic [3:0] CRN_MISC  = 4'd15;

  // TLB operations on register 8
  localparam logic [2:0] OP2_TLB_ALL   = 3'd0;
  localparam logic [2:0] OP2_TLB_ENTRY = 3'd1;
  localparam logic [3:0] CRM_TLB_I     = 4'd5;
  localparam logic [3:0] CRM_TLB_D     = 4'd6;
  localparam logic [3:0] CRM_TLB_ID    = 4'd7;

  // Clock and idle operations on register 15
  localparam logic [2:0] OP2_CLOCK   = 3'd2;
  localparam logic [3:0] CRM_CLK_SW1 = 4'd1;
  localparam logic [3:0] CRM_CLK_SW2 = 4'd2;
  localparam logic [3:0] CRM_WFI     = 4'd8;

  // Register values and store masks
  localparam logic [31:0] ID_VALUE   = 32'h6901_B118;
  localparam logic [31:0] CTRL_RESET = 32'h0000_0070;
  localparam logic [31:0] TTB_MASK   = 32'hFFFF_C000;
  localparam logic [31:0] PID_MASK   = 32'hFC00_0000;

  // Classified access passed from decode to execute
  typedef struct packed {
    logic        rd;       // read: return bank entry idx
    logic        to_pc;    // read to PC: update flags
    logic        wr;       // store data into bank entry idx
    logic [3:0]  idx;
    logic [31:0] data;     // already masked for the target register
    logic        flush_i;
    logic        flush_d;
    logic        flush_e;
    logic        idle;
    logic        bad;
  } scc_op_t;

  // One result item
  typedef struct packed {
    logic        bad_access;
    logic        enter_idle;
    logic [31:0] flush_address;
    logic        flush_data_entry;
    logic        dtlb_flush;
    logic        itlb_flush;
    logic [3:0]  nzcv;
    logic        flags_update;
    logic [31:0] read_data;
  } scc_result_t;

endpackage

// ----- hdl/system_control_coprocessor.sv -----
// Top level of the system control coprocessor: decode, queue and execute
`timescale 1ns / 1ps
// One item is one coprocessor access (read or write of a system control
// register) and gives exactly one result item. The block takes one item per
// clock and delivers one result per clock while out_tready stays high. An
// item accepted at the input handshake is stored in a decode queue slot,
// then taken by the execute stage into its result register, which raises
// out_tvalid: one queue slot followed by the execute result register. The
// queue holds QUEUE_DEPTH decoded items, so the input side keeps accepting
// while a result waits to be taken, until the queue is full.
// Accesses are carried out in order against the internal register bank, so a
// read always sees every earlier write.
module system_control_coprocessor #(
  parameter int QUEUE_DEPTH = scc_pkg::SCC_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // crn[3:0], crm[7:4], opcode2[10:8], dest_is_pc[11], write_data[43:12], zero[47:44]
  input  logic [scc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_data[31:0], flags_update[32], nzcv[36:33], instruction TLB flush[37],
  // data TLB flush[38], flush_data_entry[39], flush_address[71:40],
  // enter_idle[72], bad_access[73], zero[79:74]
  output logic [scc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import scc_pkg::*;

  scc_op_t     dec_op;
  scc_op_t     q_op;
  logic        q_valid;
  logic        q_ready;
  scc_result_t res;

  // Front end
  scc_decode u_decode (
    .cmd        (in_tuser),
    .crn        (in_tdata[3:0]),
    .crm        (in_tdata[7:4]),
    .opcode2    (in_tdata[10:8]),
    .dest_is_pc (in_tdata[11]),
    .write_data (in_tdata[43:12]),
    .op         (dec_op)
  );

  scc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_op    (dec_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  // Back end
  scc_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Result packing, zero padding above the result fields
  assign out_tdata = {6'd0, res};

endmodule

// ----- hdl/scc_decode.sv -----
// Front end: classifies each coprocessor access into an execute operation
`timescale 1ns / 1ps
module scc_decode (
  input  logic             cmd,
  input  logic [3:0]       crn,
  input  logic [3:0]       crm,
  input  logic [2:0]       opcode2,
  input  logic             dest_is_pc,
  input  logic [31:0]      write_data,
  output scc_pkg::scc_op_t op
);
  import scc_pkg::*;

  logic sub_zero;

  assign sub_zero = (crm == 4'd0) && (opcode2 == 3'd0);

  // Access classification
  always_comb begin
    op       = '0;
    op.idx   = crn;
    op.data  = write_data;
    if (cmd == CMD_MRC) begin
      op.rd    = 1'b1;
      op.to_pc = dest_is_pc;
      // write-only registers, and fault registers with a sub-register
      if (crn == CRN_CACHE || crn == CRN_TLB || crn == CRN_MISC) begin
        op.bad = 1'b1;
      end
      if ((crn == CRN_FSR || crn == CRN_FAR) && !sub_zero) begin
        op.bad = 1'b1;
      end
    end else begin
      case (crn)
        CRN_CTRL, CRN_DAC, CRN_CACHE, CRN_RBL: begin
          op.wr = 1'b1;
        end
        CRN_TTB: begin
          op.wr   = 1'b1;
          op.data = write_data & TTB_MASK;
        end
        CRN_FSR, CRN_FAR: begin
          op.wr  = 1'b1;
          op.bad = !sub_zero;
        end
        CRN_TLB: begin
          if (opcode2 == OP2_TLB_ALL && crm == CRM_TLB_I) begin
            op.flush_i = 1'b1;
          end else if (opcode2 == OP2_TLB_ALL && crm == CRM_TLB_D) begin
            op.flush_d = 1'b1;
          end else if (opcode2 == OP2_TLB_ALL && crm == CRM_TLB_ID) begin
            op.flush_i = 1'b1;
            op.flush_d = 1'b1;
          end else if (opcode2 == OP2_TLB_ENTRY && crm == CRM_TLB_D) begin
            op.flush_e = 1'b1;
          end else begin
            op.bad = 1'b1;
          end
        end
        CRN_PID: begin
          // only the process ID access stores; others are quietly ignored
          op.wr   = sub_zero;
          op.data = write_data & PID_MASK;
        end
        CRN_MISC: begin
          if (opcode2 == OP2_CLOCK && (crm == CRM_CLK_SW1 || crm == CRM_CLK_SW2)) begin
            op.bad = 1'b0;
          end else if (opcode2 == OP2_CLOCK && crm == CRM_WFI) begin
            op.idle = 1'b1;
          end else begin
            op.bad = 1'b1;
          end
        end
        default: begin
          op.bad = 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- hdl/scc_queue.sv -----
// Short in-order queue of decoded operations between front and back end
`timescale 1ns / 1ps
`include "system_control_coprocessor_macros.svh"
module scc_queue #(
  parameter int DEPTH = scc_pkg::SCC_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  scc_pkg::scc_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output scc_pkg::scc_op_t pop_op
);
  import scc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scc_op_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  `SCC_ASSERT_ALW(a_cnt_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue overfilled")
  `SCC_ASSERT_NXT(a_cnt_track, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "count lost a push")
  `SCC_ASSERT_NXT(a_fall_thru, clk, rst_n, push && (count_r == '0), pop_op == $past(push_op), "item into empty queue not at head")

endmodule

// ----- hdl/scc_exec.sv -----
// Back end: register bank, operation execution and result register
`timescale 1ns / 1ps
`include "system_control_coprocessor_macros.svh"
module scc_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  scc_pkg::scc_op_t     op,
  output logic                 res_valid,
  input  logic                 res_ready,
  output scc_pkg::scc_result_t res
);
  import scc_pkg::*;

  logic [31:0]  bank_r [16];
  scc_result_t  res_r, res_nxt;
  logic         res_valid_r, res_valid_nxt;
  logic         take;
  logic [31:0]  rd_val;

  assign op_ready  = !res_valid_r || res_ready;
  assign take      = op_valid && op_ready;
  assign rd_val    = bank_r[op.idx];
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Result formation
  always_comb begin
    res_nxt                  = '0;
    res_nxt.read_data        = op.rd ? rd_val : '0;
    res_nxt.flags_update     = op.rd && op.to_pc;
    res_nxt.nzcv             = (op.rd && op.to_pc) ? rd_val[31:28] : 4'd0;
    res_nxt.itlb_flush       = op.flush_i;
    res_nxt.dtlb_flush       = op.flush_d;
    res_nxt.flush_data_entry = op.flush_e;
    res_nxt.flush_address    = op.flush_e ? bank_r[CRN_FAR] : '0;
    res_nxt.enter_idle       = op.idle;
    res_nxt.bad_access       = op.bad;
    res_valid_nxt            = take || (res_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  // Register bank; entry 0 is never stored by the decoder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 2; i < 16; i++) begin
        bank_r[i] <= '0;
      end
      bank_r[CRN_ID]   <= ID_VALUE;
      bank_r[CRN_CTRL] <= CTRL_RESET;
    end else if (take && op.wr) begin
      bank_r[op.idx] <= op.data;
    end
  end

  `SCC_ASSERT_ALW(a_id_fixed, clk, rst_n, bank_r[CRN_ID] == ID_VALUE, "ID register changed")
  `SCC_ASSERT_NXT(a_ttb_mask, clk, rst_n, take && op.wr && (op.idx == CRN_TTB), bank_r[CRN_TTB][13:0] == 14'd0, "TTB low bits stored")
  `SCC_ASSERT_IMP(a_nzcv_src, clk, rst_n, res_valid_r && res_r.flags_update, res_r.nzcv == res_r.read_data[31:28], "flags not from read value")

endmodule
